// File: sv/dith4_pkg.sv
// ----------------------------------------------------------------------------
// dith4_pkg
// Shared types, constants and helpers of the four-level error-diffusion dither.
// ----------------------------------------------------------------------------
`default_nettype none

package dith4_pkg;

  // Field and register widths
  localparam int unsigned PixW      = 8;
  localparam int unsigned LevelW    = 2;
  localparam int unsigned ErrW      = 8;
  localparam int unsigned WidthRegW = 11;
  localparam int unsigned HeightW   = 16;
  localparam int unsigned CfgDataW  = 16;

  // Default line length
  localparam int unsigned MaxWidthDef = 1024;

  // Register reset values
  localparam logic [WidthRegW-1:0] WidthReset  = WidthRegW'(960);
  localparam logic [HeightW-1:0]   HeightReset = HeightW'(540);

  // Level thresholds on the adjusted value
  localparam logic [PixW-1:0] ThrWhite = 8'd213;
  localparam logic [PixW-1:0] ThrLight = 8'd128;
  localparam logic [PixW-1:0] ThrDark  = 8'd43;

  // Diffusion weights in sixteenths
  localparam logic signed [3:0] WgtRight     = 4'sd7;
  localparam logic signed [3:0] WgtBelow     = 4'sd5;
  localparam logic signed [3:0] WgtBelowLeft = 4'sd3;

  // Ink levels
  typedef enum logic [LevelW-1:0] {
    LvlWhite = 2'd0,
    LvlLight = 2'd1,
    LvlDark  = 2'd2,
    LvlBlack = 2'd3
  } level_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_idx_e;

  // Stored error share
  typedef logic signed [ErrW-1:0] err_t;

  // Raster position flags of one pixel
  typedef struct packed {
    logic first_col;
    logic last_col;
    logic last_row;
    logic rd_ok;      // line entry was written in this frame
  } pos_t;

  // Grey value that a level stands for
  function automatic logic [PixW-1:0] level_value(input level_e lvl);
    logic [PixW-1:0] v;
    case (lvl)
      LvlWhite: v = 8'd255;
      LvlLight: v = 8'd170;
      LvlDark:  v = 8'd85;
      default:  v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: sv/dith4_raster.sv
// ----------------------------------------------------------------------------
// dith4_raster
// Configuration registers, column and row counters, and the per-frame fill
// count of the error line.
// ----------------------------------------------------------------------------
`default_nettype none

module dith4_raster import dith4_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef,
  localparam int unsigned ColW = $clog2(MAX_WIDTH),
  localparam int unsigned FillW = $clog2(MAX_WIDTH + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire cfg_idx_e            cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                acc_i,
  output logic      [ColW-1:0]     col_o,
  output pos_t                     pos_o
);

  // Compare width wide enough for the register and for MAX_WIDTH
  localparam int unsigned CmpW = (WidthRegW > FillW) ? WidthRegW : FillW;
  localparam logic [CmpW-1:0] MaxW = CmpW'(MAX_WIDTH);

  logic [WidthRegW-1:0] width_q, width_d;
  logic [HeightW-1:0]   height_q, height_d;
  logic [ColW-1:0]      col_q, col_d;
  logic [HeightW-1:0]   row_q, row_d;
  logic [FillW-1:0]     fill_q, fill_d;

  logic [CmpW-1:0]      w_eff;
  logic [HeightW-1:0]   h_eff;
  logic [FillW-1:0]     col_inc;
  logic                 frame_start;
  logic                 last_col;
  logic                 last_row;

  // Write configuration
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgImageWidth:  width_d  = cfg_wdata_i[WidthRegW-1:0];
        CfgImageHeight: height_d = cfg_wdata_i[HeightW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size
  always_comb begin
    w_eff = CmpW'(width_q);
    if (width_q == '0) w_eff = CmpW'(1);
    else if (CmpW'(width_q) > MaxW) w_eff = MaxW;
    h_eff = (height_q == '0) ? HeightW'(1) : height_q;
  end

  assign col_inc     = FillW'(col_q) + FillW'(1);
  assign last_col    = CmpW'(col_inc) >= w_eff;
  assign last_row    = ({1'b0, row_q} + 17'd1) >= {1'b0, h_eff};
  assign frame_start = (col_q == '0) && (row_q == '0);

  assign col_o = col_q;
  assign pos_o = '{first_col: (col_q == '0),
                   last_col:  last_col,
                   last_row:  last_row,
                   rd_ok:     !frame_start && (FillW'(col_q) < fill_q)};

  // Advance the raster position and the fill count
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    fill_d = fill_q;
    if (acc_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + HeightW'(1);
      end else begin
        col_d = col_inc[ColW-1:0];
      end
      if (frame_start) fill_d = FillW'(1);
      else if (col_inc > fill_q) fill_d = col_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      col_q    <= '0;
      row_q    <= '0;
      fill_q   <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      fill_q   <= fill_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/dith4_line_mem.sv
// ----------------------------------------------------------------------------
// dith4_line_mem
// Error line store: one write and one registered read per cycle, with a
// capture of a write that lands on the entry being read.
// ----------------------------------------------------------------------------
`default_nettype none

module dith4_line_mem import dith4_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef,
  localparam int unsigned ColW = $clog2(MAX_WIDTH)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic [ColW-1:0] rd_addr_i,
  input  wire logic            wr_en_i,
  input  wire logic [ColW-1:0] wr_addr_i,
  input  wire err_t            wr_data_i,
  output err_t                 rd_data_o,
  output logic                 fwd_hit_o,
  output err_t                 fwd_data_o
);

  err_t mem_q [MAX_WIDTH];
  err_t rd_q;
  err_t fwd_data_q;
  logic fwd_hit_q, fwd_hit_d;

  // Write and read the line; the read sees the old entry on a collision
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    if (en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // Flag a same-cycle write to the entry being read
  always_comb begin
    fwd_hit_d = fwd_hit_q;
    if (en_i) fwd_hit_d = wr_en_i && (wr_addr_i == rd_addr_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= fwd_hit_d;
    end
  end

  assign rd_data_o  = rd_q;
  assign fwd_hit_o  = fwd_hit_q;
  assign fwd_data_o = fwd_data_q;

endmodule

`default_nettype wire

// File: sv/dith4_quant.sv
// ----------------------------------------------------------------------------
// dith4_quant
// Compute stage: adds carried errors, quantizes to four levels, spreads the
// error and writes back the line, then holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module dith4_quant import dith4_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef,
  localparam int unsigned ColW = $clog2(MAX_WIDTH)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            acc_i,
  input  wire logic [PixW-1:0] pix_i,
  input  wire logic [ColW-1:0] col_i,
  input  wire pos_t            pos_i,
  input  wire err_t            rd_data_i,
  input  wire logic            fwd_hit_i,
  input  wire err_t            fwd_data_i,
  output logic                 wr_en_o,
  output logic      [ColW-1:0] wr_addr_o,
  output err_t                 wr_data_o,
  output logic                 out_valid_o,
  output level_e               ink_o,
  output logic                 row_end_o,
  output logic                 frame_end_o
);

  // Stage A: accepted pixel waiting for its line read
  logic            a_valid_q, a_valid_d;
  logic [PixW-1:0] a_pix_q;
  logic [ColW-1:0] a_col_q;
  pos_t            a_pos_q;

  // Diffusion state
  err_t            rc_q, rc_d;
  err_t            pbr_q, pbr_d;
  err_t            part_q, part_d;
  logic [ColW-1:0] part_addr_q, part_addr_d;
  logic            part_valid_q, part_valid_d;

  // Result word
  logic            out_valid_q, out_valid_d;
  level_e          ink_q;
  logic            row_end_q;
  logic            frame_end_q;

  logic               step;
  logic               part_hit;
  err_t               below;
  err_t               rc_in;
  err_t               pbr_in;
  logic signed [9:0]  val;
  logic [PixW-1:0]    vc;
  level_e             lvl;
  logic signed [8:0]  err;
  logic signed [11:0] err_x;
  err_t               f7, f5, f3, f1;
  err_t               add3;

  assign step = en_i && a_valid_q;

  // Pick the newest copy of this column's line entry
  assign part_hit = part_valid_q && (part_addr_q == a_col_q);
  always_comb begin
    below = '0;
    if (a_pos_q.rd_ok) begin
      if (part_hit) below = part_q;
      else if (fwd_hit_i) below = fwd_data_i;
      else below = rd_data_i;
    end
  end

  assign rc_in  = a_pos_q.first_col ? err_t'(0) : rc_q;
  assign pbr_in = a_pos_q.first_col ? err_t'(0) : pbr_q;

  // Adjust, clamp and quantize
  assign val = $signed({2'b00, a_pix_q}) + 10'(rc_in) + 10'(below);
  always_comb begin
    if (val < 0) vc = '0;
    else if (val > 10'sd255) vc = 8'd255;
    else vc = val[PixW-1:0];
    if (vc >= ThrWhite) lvl = LvlWhite;
    else if (vc >= ThrLight) lvl = LvlLight;
    else if (vc >= ThrDark) lvl = LvlDark;
    else lvl = LvlBlack;
  end

  // Weigh the error in sixteenths, floor by arithmetic shift
  assign err   = $signed({1'b0, vc}) - $signed({1'b0, level_value(lvl)});
  assign err_x = 12'(err);
  assign f7    = err_t'((err_x * 12'(WgtRight)) >>> 4);
  assign f5    = err_t'((err_x * 12'(WgtBelow)) >>> 4);
  assign f3    = err_t'((err_x * 12'(WgtBelowLeft)) >>> 4);
  assign f1    = err_t'(err_x >>> 4);

  assign add3 = (a_pos_q.first_col || a_pos_q.last_row) ? err_t'(0) : f3;

  // Write back the finished entry of the previous column
  assign wr_en_o   = step && part_valid_q;
  assign wr_addr_o = part_addr_q;
  assign wr_data_o = err_t'(part_q + add3);

  // Advance the diffusion state
  always_comb begin
    rc_d         = rc_q;
    pbr_d        = pbr_q;
    part_d       = part_q;
    part_addr_d  = part_addr_q;
    part_valid_d = part_valid_q;
    if (step) begin
      rc_d         = f7;
      pbr_d        = (a_pos_q.last_row || a_pos_q.last_col) ? err_t'(0) : f1;
      part_d       = a_pos_q.last_row ? err_t'(0) : err_t'(pbr_in + f5);
      part_addr_d  = a_col_q;
      part_valid_d = 1'b1;
    end
  end

  assign a_valid_d   = en_i ? acc_i : a_valid_q;
  assign out_valid_d = en_i ? a_valid_q : out_valid_q;

  // Hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_pix_q <= pix_i;
      a_col_q <= col_i;
      a_pos_q <= pos_i;
    end
    if (step) begin
      ink_q       <= lvl;
      row_end_q   <= a_pos_q.last_col;
      frame_end_q <= a_pos_q.last_col && a_pos_q.last_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      rc_q         <= '0;
      pbr_q        <= '0;
      part_q       <= '0;
      part_addr_q  <= '0;
      part_valid_q <= 1'b0;
    end else begin
      a_valid_q    <= a_valid_d;
      out_valid_q  <= out_valid_d;
      rc_q         <= rc_d;
      pbr_q        <= pbr_d;
      part_q       <= part_d;
      part_addr_q  <= part_addr_d;
      part_valid_q <= part_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ink_o       = ink_q;
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

endmodule

`default_nettype wire

// File: sv/four_level_error_diffusion_dither_core.sv
// ----------------------------------------------------------------------------
// four_level_error_diffusion_dither_core
// Floyd-Steinberg dither of 8-bit grey pixels to four ink levels.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake         Payload
// s_axis    in   tvalid / tready   tdata[7:0] grey_pixel
// m_axis    out  tvalid / tready   tdata[1:0] ink_level, tlast row_end,
//                                  tuser frame_end
// cfg       in   cfg_we_i          cfg_idx_i (0 width, 1 height), cfg_wdata_i
//
// One pixel per clock unless the output stalls; stage A holds the pixel, then
// the result word is registered. The carry loop (add, clamp, quantize, weigh)
// closes in the compute stage; the line takes one read and one write per cycle.
// Reset needs no clearing pass: a fill count marks the line entries written
// in the current frame and all others read as zero.
// A stalled output holds the whole pipeline, and s_axis_tready drops with it.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_error_diffusion_dither_core import dith4_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration writes
  input  wire logic                cfg_we_i,
  input  wire cfg_idx_e            cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // Pixel input
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] grey_pixel
  // Level output
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [7:0]          m_axis_tdata,   // [1:0] ink_level, [7:2] zero
  output logic                     m_axis_tlast,
  output logic                     m_axis_tuser    // [0] frame_end
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);

  logic            en;
  logic            acc;
  logic [ColW-1:0] col;
  pos_t            pos;
  err_t            rd_data;
  logic            fwd_hit;
  err_t            fwd_data;
  logic            wr_en;
  logic [ColW-1:0] wr_addr;
  err_t            wr_data;
  logic            out_valid;
  level_e          ink;
  logic            row_end;
  logic            frame_end;

  // Advance the pipeline unless a result word is stuck
  assign en            = !out_valid || m_axis_tready;
  assign acc           = s_axis_tvalid && en;
  assign s_axis_tready = en;

  dith4_raster #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .col_o       (col),
    .pos_o       (pos)
  );

  dith4_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .rd_addr_i  (col),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd_data_o  (rd_data),
    .fwd_hit_o  (fwd_hit),
    .fwd_data_o (fwd_data)
  );

  dith4_quant #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_quant (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .acc_i       (acc),
    .pix_i       (s_axis_tdata),
    .col_i       (col),
    .pos_i       (pos),
    .rd_data_i   (rd_data),
    .fwd_hit_i   (fwd_hit),
    .fwd_data_i  (fwd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid),
    .ink_o       (ink),
    .row_end_o   (row_end),
    .frame_end_o (frame_end)
  );

  // Drive the result word
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, ink};
  assign m_axis_tlast  = row_end;
  assign m_axis_tuser  = frame_end;

endmodule

`default_nettype wire
